[rtl/vrp_pkg.sv]
// vrp_pkg: shared constants and register codes for the vertex rotate/project block.
// No dependencies; imported by every module under rtl/.
package vrp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int TRIG_WIDTH_DEF  = 16;

  localparam int CFG_DATA_W = 16;
  localparam int VIEW_W     = 12;

  typedef enum logic [1:0] {
    REG_YAW    = 2'd0,
    REG_PITCH  = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  localparam logic [VIEW_W-1:0] VIEW_W_RST = 12'd640;
  localparam logic [VIEW_W-1:0] VIEW_H_RST = 12'd480;

  // Q2.30 trig core
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;

  // Register depth of the free-running trig chain, measured from the angle register.
  localparam int TRIG_LAT = 18;
  // Payload delay ahead of the first use of sine/cosine.
  localparam int ROT_DLY  = TRIG_LAT + 1;

  // Projection: scale 0.15 and centre /2 give a divisor of 200 * 2^frac = 25 * 2^(frac+3).
  localparam int SCALE_DEN  = 100;
  localparam int SCALE_NUM2 = 30;
  localparam int DIV_ODD    = 25;
  localparam int BIAS_LOG   = 19;
  localparam int NB_W       = 25;

endpackage

[rtl/vertex_rotate_project.sv]
// vertex_rotate_project: yaw then pitch rotation and orthographic projection, one vertex/cycle unless out_ready stalls.
// Pipeline from input accept to result valid: 19-stage payload delay, 4 rotation, 4 projection stages;
// throughput one request per cycle while out_ready is high, set by the register pipeline.
// Reset: angles 0, view 640x480, pipeline empty; the trig chains settle before a vertex leaves the
// payload delay, so requests may follow reset at once.
// Uses vrp_pkg, vrp_trig, vrp_hstep, vrp_xform, vrp_project.
module vertex_rotate_project #(
  parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = vrp_pkg::ANGLE_WIDTH_DEF,
  parameter int TRIG_WIDTH  = vrp_pkg::TRIG_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_z,
  input  logic                          in_last_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            out_screen_x,
  output logic signed [15:0]            out_screen_y,
  output logic                          out_last_result,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [vrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vrp_pkg::*;

  logic [15:0]       yaw_r, pitch_r;
  logic [VIEW_W-1:0] vw_r, vh_r;

  logic signed [TRIG_WIDTH-1:0] sin_yaw, cos_yaw, sin_pitch, cos_pitch;

  logic                          rot_valid, rot_ready, rot_last;
  logic signed [COORD_WIDTH+1:0] rot_xr;
  logic signed [COORD_WIDTH+3:0] rot_yr;

  // Configuration registers: the user must write them only while the pipeline is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r   <= '0;
      pitch_r <= '0;
      vw_r    <= VIEW_W_RST;
      vh_r    <= VIEW_H_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_YAW:    yaw_r   <= cfg_wdata;
        REG_PITCH:  pitch_r <= cfg_wdata;
        REG_WIDTH:  vw_r    <= cfg_wdata[VIEW_W-1:0];
        REG_HEIGHT: vh_r    <= cfg_wdata[VIEW_W-1:0];
        default:    ;
      endcase
    end
  end

  // Sine/cosine run continuously off the angle registers; no handshake needed.
  vrp_trig #(.AW(ANGLE_WIDTH), .TW(TRIG_WIDTH)) u_trig_yaw (
    .clk(clk), .angle(yaw_r), .sin_o(sin_yaw), .cos_o(cos_yaw)
  );

  vrp_trig #(.AW(ANGLE_WIDTH), .TW(TRIG_WIDTH)) u_trig_pitch (
    .clk(clk), .angle(pitch_r), .sin_o(sin_pitch), .cos_o(cos_pitch)
  );

  // Rotation: delay the vertex past the trig settle time, then rotate.
  vrp_xform #(.CW(COORD_WIDTH), .TW(TRIG_WIDTH)) u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_vertex_x),
    .in_y      (in_vertex_y),
    .in_z      (in_vertex_z),
    .in_last   (in_last_vertex),
    .sin_yaw   (sin_yaw),
    .cos_yaw   (cos_yaw),
    .sin_pitch (sin_pitch),
    .cos_pitch (cos_pitch),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_xr    (rot_xr),
    .out_yr    (rot_yr),
    .out_last  (rot_last)
  );

  // Projection and saturation; its last stage is the output register.
  vrp_project #(.CW(COORD_WIDTH)) u_project (
    .clk       (clk),
    .rst_n     (rst_n),
    .view_w    (vw_r),
    .view_h    (vh_r),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_xr     (rot_xr),
    .in_yr     (rot_yr),
    .in_last   (rot_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_screen_x),
    .out_y     (out_screen_y),
    .out_last  (out_last_result)
  );

endmodule

[rtl/vrp_hstep.sv]
// vrp_hstep: one Horner step of the Taylor series, s_out = 1 - floor((x2 * s_in) / K) in Q2.30.
// Three register stages: multiply, reciprocal estimate, correction. Uses vrp_pkg.
module vrp_hstep #(
  parameter int unsigned K = 2
) (
  input  logic        clk,
  input  logic [29:0] x2,
  input  logic [30:0] s_in,
  output logic [30:0] s_out
);
  import vrp_pkg::*;

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
  localparam logic [30:0] KV    = 31'(K);

  logic [60:0] prod_p;
  logic [62:0] prod_q;
  logic [30:0] p_r, pd_r, q0_r, s_r;
  logic [30:0] q0k, rem, q;

  assign prod_p = {31'b0, x2} * {30'b0, s_in};
  assign prod_q = {32'b0, p_r} * {31'b0, RECIP};
  assign q0k    = q0_r * KV;
  assign rem    = pd_r - q0k;
  assign q      = q0_r + 31'(rem >= KV);

  always_ff @(posedge clk) begin
    p_r  <= prod_p[60:30];
    q0_r <= prod_q[62:32];
    pd_r <= p_r;
    s_r  <= ONE_Q30 - q;
  end

  assign s_out = s_r;

endmodule

[rtl/vrp_trig.sv]
// vrp_trig: free-running sine/cosine chain for one angle register, Q1.(TW-1) outputs.
// Uses vrp_pkg and vrp_hstep; settles once the changed angle has passed the whole register chain.
module vrp_trig #(
  parameter int AW = vrp_pkg::ANGLE_WIDTH_DEF,
  parameter int TW = vrp_pkg::TRIG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic [15:0]          angle,
  output logic signed [TW-1:0] sin_o,
  output logic signed [TW-1:0] cos_o
);
  import vrp_pkg::*;

  localparam int TF = TW - 1;
  localparam int SH = 30 - TF;
  localparam int unsigned SK [4] = '{72, 42, 20, 6};
  localparam int unsigned CK [5] = '{90, 56, 30, 12, 2};
  localparam logic [31:0] QHALF = 32'd1 << (SH - 1);
  localparam logic [31:0] QTOP  = (32'd1 << TF) - 32'd1;

  logic [31:0] t;
  logic [2:0]  oct_r;
  logic [29:0] r30, x_r, x2_r;
  logic [61:0] prod_x;
  logic [59:0] prod_x2;
  logic [60:0] prod_s;
  logic [30:0] s_chain [5];
  logic [30:0] c_chain [6];
  logic [30:0] sfin_r;
  logic [31:0] vs, vc, qs_f, qc_f;
  logic signed [TW-1:0] qs, qc, sin_nxt, cos_nxt, sin_r, cos_r;

  // Left-align the low AW angle bits as a 32-bit fraction of a turn.
  assign t   = {16'b0, angle} << (32 - AW);
  assign r30 = t[29] ? (30'h2000_0000 - {1'b0, t[28:0]}) : {1'b0, t[28:0]};

  assign prod_x  = {32'b0, r30} * {30'b0, PI_Q30};
  assign prod_x2 = x_r * x_r;

  always_ff @(posedge clk) begin
    oct_r <= t[31:29];
    x_r   <= prod_x[60:31];
    x2_r  <= prod_x2[59:30];
  end

  assign s_chain[0] = ONE_Q30;
  assign c_chain[0] = ONE_Q30;

  for (genvar g = 0; g < 4; g++) begin : g_sin
    vrp_hstep #(.K(SK[g])) u_step (
      .clk(clk), .x2(x2_r), .s_in(s_chain[g]), .s_out(s_chain[g+1])
    );
  end

  for (genvar g = 0; g < 5; g++) begin : g_cos
    vrp_hstep #(.K(CK[g])) u_step (
      .clk(clk), .x2(x2_r), .s_in(c_chain[g]), .s_out(c_chain[g+1])
    );
  end

  assign prod_s = {31'b0, x_r} * {30'b0, s_chain[4]};

  always_ff @(posedge clk) begin
    sfin_r <= prod_s[60:30];
  end

  // Round to the output format; exactly 1.0 saturates to the largest code.
  assign vs   = {1'b0, sfin_r} + QHALF;
  assign vc   = {1'b0, c_chain[5]} + QHALF;
  assign qs_f = vs >> SH;
  assign qc_f = vc >> SH;
  assign qs   = $signed({1'b0, (qs_f > QTOP) ? QTOP[TF-1:0] : qs_f[TF-1:0]});
  assign qc   = $signed({1'b0, (qc_f > QTOP) ? QTOP[TF-1:0] : qc_f[TF-1:0]});

  always_comb begin
    case (oct_r)
      3'd0:    begin sin_nxt = qs;  cos_nxt = qc;  end
      3'd1:    begin sin_nxt = qc;  cos_nxt = qs;  end
      3'd2:    begin sin_nxt = qc;  cos_nxt = -qs; end
      3'd3:    begin sin_nxt = qs;  cos_nxt = -qc; end
      3'd4:    begin sin_nxt = -qs; cos_nxt = -qc; end
      3'd5:    begin sin_nxt = -qc; cos_nxt = -qs; end
      3'd6:    begin sin_nxt = -qc; cos_nxt = qs;  end
      default: begin sin_nxt = -qs; cos_nxt = qc;  end
    endcase
  end

  always_ff @(posedge clk) begin
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

[rtl/vrp_xform.sv]
// vrp_xform: payload delay line plus the yaw and pitch rotation stages.
// Uses vrp_pkg; sine/cosine come from two vrp_trig instances at the top level.
module vrp_xform #(
  parameter int CW = vrp_pkg::COORD_WIDTH_DEF,
  parameter int TW = vrp_pkg::TRIG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [CW-1:0] in_z,
  input  logic                 in_last,
  input  logic signed [TW-1:0] sin_yaw,
  input  logic signed [TW-1:0] cos_yaw,
  input  logic signed [TW-1:0] sin_pitch,
  input  logic signed [TW-1:0] cos_pitch,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CW+1:0] out_xr,
  output logic signed [CW+3:0] out_yr,
  output logic                 out_last
);
  import vrp_pkg::*;

  localparam int TF = TW - 1;
  localparam int PW = CW + TW;
  localparam int RW = CW + TW + 2;
  localparam int NS = ROT_DLY + 4;
  localparam int SA = ROT_DLY;
  localparam int SB = SA + 1;
  localparam int SC = SA + 2;
  localparam int SD = SA + 3;
  localparam logic signed [PW:0] HALF_P = (PW+1)'(1) << (TF - 1);
  localparam logic signed [RW:0] HALF_R = (RW+1)'(1) << (TF - 1);

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  logic signed [CW-1:0] dx_r [ROT_DLY];
  logic signed [CW-1:0] dy_r [ROT_DLY];
  logic signed [CW-1:0] dz_r [ROT_DLY];
  logic                 dl_r [ROT_DLY];

  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [CW-1:0] ya_r, yb_r;
  logic                 la_r, lb_r, lc_r, ld_r;
  logic signed [PW:0]   sx, sz;
  logic signed [CW+1:0] xb_r, zb_r, xc_r, xd_r;
  logic signed [RW-1:0] p5_r, p6_r;
  logic signed [RW:0]   sy;
  logic signed [CW+3:0] yd_r;

  // Stage i advances when empty or when the stage after it advances.
  always_comb begin
    rdy[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Delay line: hold the vertex until the trig chain has settled on the current angles.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx_r[0] <= in_x;
      dy_r[0] <= in_y;
      dz_r[0] <= in_z;
      dl_r[0] <= in_last;
    end
    for (int i = 1; i < ROT_DLY; i++) begin
      if (rdy[i]) begin
        dx_r[i] <= dx_r[i-1];
        dy_r[i] <= dy_r[i-1];
        dz_r[i] <= dz_r[i-1];
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  assign sx = PW'(p1_r) + PW'(p2_r) + HALF_P;
  assign sz = (PW+1)'(p3_r) - (PW+1)'(p4_r) + HALF_P;
  assign sy = (RW+1)'(p5_r) - (RW+1)'(p6_r) + HALF_R;

  always_ff @(posedge clk) begin
    if (rdy[SA]) begin
      p1_r <= dx_r[SA-1] * cos_yaw;
      p2_r <= dz_r[SA-1] * sin_yaw;
      p3_r <= dz_r[SA-1] * cos_yaw;
      p4_r <= dx_r[SA-1] * sin_yaw;
      ya_r <= dy_r[SA-1];
      la_r <= dl_r[SA-1];
    end
    if (rdy[SB]) begin
      xb_r <= sx[PW:TF];
      zb_r <= sz[PW:TF];
      yb_r <= ya_r;
      lb_r <= la_r;
    end
    if (rdy[SC]) begin
      p5_r <= yb_r * cos_pitch;
      p6_r <= zb_r * sin_pitch;
      xc_r <= xb_r;
      lc_r <= lb_r;
    end
    if (rdy[SD]) begin
      yd_r <= sy[RW:TF];
      xd_r <= xc_r;
      ld_r <= lc_r;
    end
  end

  assign in_ready  = rdy[0] && rst_n;
  assign out_valid = v_r[SD];
  assign out_xr    = xd_r;
  assign out_yr    = yd_r;
  assign out_last  = ld_r;

endmodule

[rtl/vrp_project.sv]
// vrp_project: orthographic projection, divide by 25 * 2^(frac+3), saturate to 16 bits.
// Uses vrp_pkg; fed by vrp_xform, drives the result channel.
module vrp_project #(
  parameter int CW = vrp_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [vrp_pkg::VIEW_W-1:0] view_w,
  input  logic [vrp_pkg::VIEW_W-1:0] view_h,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CW+1:0]     in_xr,
  input  logic signed [CW+3:0]     in_yr,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       out_x,
  output logic signed [15:0]       out_y,
  output logic                     out_last
);
  import vrp_pkg::*;

  localparam int CF  = CW - 4;
  localparam int XW  = CW + 2;
  localparam int YW  = CW + 4;
  localparam int PW  = CW + 26;
  localparam int SHF = CF + 3;
  localparam logic [31:0]   RECIP25 = 32'((64'd1 << 32) / DIV_ODD);
  localparam logic [NB_W-1:0] DIVK  = NB_W'(DIV_ODD);
  localparam logic signed [PW-1:0] BIAS = PW'(DIV_ODD * (1 << BIAS_LOG));
  localparam logic signed [NB_W:0] QOFF = (NB_W+1)'(1 << BIAS_LOG);
  localparam logic signed [NB_W:0] SMAX = (NB_W+1)'(32767);
  localparam logic signed [NB_W:0] SMIN = -(NB_W+1)'(32768);

  logic [3:0] v_r;
  logic [4:0] rdy;

  logic [VIEW_W-1:0]      m;
  logic signed [VIEW_W:0] ms;
  logic signed [XW+VIEW_W:0] mx_r;
  logic signed [YW+VIEW_W:0] my_r;
  logic signed [PW-1:0] cx, cy, tx, ty, nx, ny;
  logic [NB_W-1:0] nbx_r, nby_r, nbx_d_r, nby_d_r, q0x_r, q0y_r;
  logic [NB_W+31:0] px, py;
  logic [NB_W-1:0] remx, remy, qx, qy;
  logic signed [NB_W:0] vx, vy;
  logic l1_r, l2_r, l3_r, l4_r;
  logic signed [15:0] ox_r, oy_r;

  function automatic logic signed [15:0] sat16(input logic signed [NB_W:0] v);
    if (v > SMAX) return 16'sh7FFF;
    if (v < SMIN) return -16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    rdy[4] = out_ready;
    for (int i = 3; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int i = 1; i < 4; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign m  = (view_w < view_h) ? view_w : view_h;
  assign ms = $signed({1'b0, m});

  // Centre plus half the divisor: (view + 1) * 100 * 2^frac.
  assign cx = $signed(PW'({1'b0, view_w} + 13'd1) * PW'(SCALE_DEN)) <<< CF;
  assign cy = $signed(PW'({1'b0, view_h} + 13'd1) * PW'(SCALE_DEN)) <<< CF;
  assign tx = cx + PW'(mx_r) * SCALE_NUM2;
  assign ty = cy - PW'(my_r) * SCALE_NUM2;
  assign nx = (tx >>> SHF) + BIAS;
  assign ny = (ty >>> SHF) + BIAS;

  assign px   = {{(NB_W){1'b0}}, RECIP25} * {32'b0, nbx_r};
  assign py   = {{(NB_W){1'b0}}, RECIP25} * {32'b0, nby_r};
  assign remx = nbx_d_r - q0x_r * DIVK;
  assign remy = nby_d_r - q0y_r * DIVK;
  assign qx   = q0x_r + NB_W'(remx >= DIVK);
  assign qy   = q0y_r + NB_W'(remy >= DIVK);
  assign vx   = $signed({1'b0, qx}) - QOFF;
  assign vy   = $signed({1'b0, qy}) - QOFF;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mx_r <= ms * in_xr;
      my_r <= ms * in_yr;
      l1_r <= in_last;
    end
    if (rdy[1]) begin
      nbx_r <= nx[NB_W-1:0];
      nby_r <= ny[NB_W-1:0];
      l2_r  <= l1_r;
    end
    if (rdy[2]) begin
      q0x_r   <= px[NB_W+31:32];
      q0y_r   <= py[NB_W+31:32];
      nbx_d_r <= nbx_r;
      nby_d_r <= nby_r;
      l3_r    <= l2_r;
    end
    if (rdy[3]) begin
      ox_r <= sat16(vx);
      oy_r <= sat16(vy);
      l4_r <= l3_r;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[3];
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_last  = l4_r;

endmodule
